// File: rtl/core/dsh_pkg.sv
`default_nettype none

package dsh_pkg;

  localparam int MAX_DEPTH     = 8;
  localparam int NOISE_BITS    = 15;
  localparam int HEIGHT_BITS   = 24;
  localparam int AMP_BITS      = 20;
  localparam int SMALL_BITS    = 4;
  localparam int IDX_BITS      = MAX_DEPTH + 1;
  localparam int SQ_BITS       = MAX_DEPTH;
  localparam int LVL_BITS      = 4;
  localparam int PHASE_BITS    = 3;
  localparam int SIDE          = (1 << MAX_DEPTH) + 1;
  localparam int MEM_DEPTH     = SIDE * SIDE;
  localparam int ADDR_BITS     = $clog2(MEM_DEPTH);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int NUM_CORNERS   = 4;
  localparam int CSEL_BITS     = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROUGHNESS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INIT_AMP  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_TL = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_TR = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_BL = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_BR = 3'd6;

  typedef struct packed {
    logic                 take;
    logic                 corner_wr;
    logic [CSEL_BITS-1:0] corner_sel;
    logic                 rd_en;
    logic [CSEL_BITS-1:0] rd_sel;
    logic                 calc_base;
    logic                 calc_final;
    logic                 commit;
  } cmd_t;

  typedef struct packed {
    logic start_gen;
    logic phase_zero;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/diamond_square_height_fill.sv
// Per request: an edge point computes from the cached corners, a square centre first
// reads its four corners from the grid, and the first centre of a generation first
// writes the four configured corners. Requests stall until the previous point is
// committed to the output register; the grid memory has a single read port.
// Reset: controller idle, walk at the first centre, registers at their reset values.
// The grid memory is not cleared; every read hits a point written in the same generation.
`default_nettype none

module diamond_square_height_fill (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [dsh_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [dsh_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [dsh_pkg::NOISE_BITS-1:0]        in_noise_word,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [dsh_pkg::IDX_BITS-1:0]               out_row,
  output logic [dsh_pkg::IDX_BITS-1:0]               out_col,
  output logic signed [dsh_pkg::HEIGHT_BITS-1:0]     out_height,
  output logic                                       out_last
);

  dsh_pkg::cmd_t    cmd;
  dsh_pkg::status_t status;

  logic [dsh_pkg::IDX_BITS-1:0]          res_row, res_col;
  logic signed [dsh_pkg::HEIGHT_BITS-1:0] res_height;
  logic                                  res_last;

  logic                                  out_valid_r;
  logic [dsh_pkg::IDX_BITS-1:0]          out_row_r, out_col_r;
  logic signed [dsh_pkg::HEIGHT_BITS-1:0] out_height_r;
  logic                                  out_last_r;
  logic                                  out_free;

  // Output register parts the two sides: the next request is taken while a
  // finished point still waits downstream. Hold the commit until it drains.
  assign out_free = !out_valid_r || !out_stall;

  dsh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .out_free (out_free),
    .cmd      (cmd)
  );

  dsh_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_noise_word (in_noise_word),
    .cmd           (cmd),
    .status        (status),
    .res_row       (res_row),
    .res_col       (res_col),
    .res_height    (res_height),
    .res_last      (res_last)
  );

  // Load on commit, drop valid once the point is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; advance only on commit so a stalled point holds.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_row_r    <= res_row;
      out_col_r    <= res_col;
      out_height_r <= res_height;
      out_last_r   <= res_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_height = out_height_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/dsh_ctrl.sv
`default_nettype none

module dsh_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dsh_pkg::status_t status,
  input  wire logic            out_free,
  output dsh_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORNER,
    S_READ,
    S_BASE,
    S_FINAL,
    S_OUT
  } state_t;

  state_t                        state_r;
  logic [dsh_pkg::CSEL_BITS-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cnt_r <= '0;
            if (status.start_gen) begin
              state_r <= S_CORNER;
            end else if (status.phase_zero) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_BASE;
            end
          end
        end
        S_CORNER: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            state_r <= S_BASE;
          end
        end
        S_BASE:  state_r <= S_FINAL;
        S_FINAL: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.take       = (state_r == S_IDLE) && in_valid;
    cmd.corner_wr  = (state_r == S_CORNER);
    cmd.corner_sel = cnt_r;
    cmd.rd_en      = (state_r == S_READ);
    cmd.rd_sel     = cnt_r;
    cmd.calc_base  = (state_r == S_BASE);
    cmd.calc_final = (state_r == S_FINAL);
    cmd.commit     = (state_r == S_OUT) && out_free;
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> out_free)
    else $error("commit while output register is blocked");

  a_start_corners: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && status.start_gen) |=>
      (state_r == S_CORNER && cnt_r == '0))
    else $error("generation start did not enter corner writes");

  a_read_to_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && cnt_r == '1) |=> state_r == S_BASE)
    else $error("corner reads did not hand over to the sum");

endmodule

`default_nettype wire

// File: rtl/core/dsh_datapath.sv
`default_nettype none

module dsh_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [dsh_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [dsh_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
  input  wire logic [dsh_pkg::NOISE_BITS-1:0]         in_noise_word,
  input  wire dsh_pkg::cmd_t                          cmd,
  output dsh_pkg::status_t                            status,
  output logic [dsh_pkg::IDX_BITS-1:0]                res_row,
  output logic [dsh_pkg::IDX_BITS-1:0]                res_col,
  output logic signed [dsh_pkg::HEIGHT_BITS-1:0]      res_height,
  output logic                                        res_last
);

  localparam int H       = dsh_pkg::HEIGHT_BITS;
  localparam int SUM_W   = H + 2;
  localparam int PROD_W  = dsh_pkg::NOISE_BITS + dsh_pkg::AMP_BITS;
  localparam int NOISE_W = dsh_pkg::AMP_BITS + 2;
  localparam int TOT_W   = H + 1;

  localparam logic [dsh_pkg::PHASE_BITS-1:0] PH_CENTRE = 3'd0;
  localparam logic [dsh_pkg::PHASE_BITS-1:0] PH_TOP    = 3'd1;
  localparam logic [dsh_pkg::PHASE_BITS-1:0] PH_LEFT   = 3'd2;
  localparam logic [dsh_pkg::PHASE_BITS-1:0] PH_BOTTOM = 3'd3;
  localparam logic [dsh_pkg::PHASE_BITS-1:0] PH_RIGHT  = 3'd4;

  function automatic logic [dsh_pkg::ADDR_BITS-1:0] grid_addr(
    input logic [dsh_pkg::IDX_BITS-1:0] rw,
    input logic [dsh_pkg::IDX_BITS-1:0] cl
  );
    // row * (2^MAX_DEPTH + 1) + col
    return (dsh_pkg::ADDR_BITS'(rw) << dsh_pkg::MAX_DEPTH) + dsh_pkg::ADDR_BITS'(rw)
           + dsh_pkg::ADDR_BITS'(cl);
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input logic [H-1:0] v);
    return {{(SUM_W - H){v[H-1]}}, v};
  endfunction

  // configuration
  logic [dsh_pkg::SMALL_BITS-1:0] depth_r;
  logic [dsh_pkg::SMALL_BITS-1:0] rough_r;
  logic [dsh_pkg::AMP_BITS-1:0]   init_amp_r;
  logic [H-1:0]                   corner_r [dsh_pkg::NUM_CORNERS];

  // walk state
  logic [dsh_pkg::LVL_BITS-1:0]   gen_depth_r;
  logic [dsh_pkg::AMP_BITS-1:0]   amp_r;
  logic [dsh_pkg::LVL_BITS-1:0]   level_r;
  logic [dsh_pkg::SQ_BITS-1:0]    sq_row_r;
  logic [dsh_pkg::SQ_BITS-1:0]    sq_col_r;
  logic [dsh_pkg::PHASE_BITS-1:0] phase_r;

  // payload
  logic [H-1:0]                   cache_r [dsh_pkg::NUM_CORNERS];
  logic [H-1:0]                   centre_r;
  logic [PROD_W-1:0]              prod_r;
  logic signed [H-1:0]            base_r;
  logic signed [NOISE_W-1:0]      noise_r;
  logic [H-1:0]                   val_r;
  logic [H-1:0]                   grid_mem [dsh_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= dsh_pkg::SMALL_BITS'(1);
      rough_r     <= dsh_pkg::SMALL_BITS'(1);
      init_amp_r  <= dsh_pkg::AMP_BITS'(256);
      corner_r[0] <= '0;
      corner_r[1] <= '0;
      corner_r[2] <= '0;
      corner_r[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsh_pkg::REG_DEPTH:     depth_r     <= cfg_wdata[dsh_pkg::SMALL_BITS-1:0];
        dsh_pkg::REG_ROUGHNESS: rough_r     <= cfg_wdata[dsh_pkg::SMALL_BITS-1:0];
        dsh_pkg::REG_INIT_AMP:  init_amp_r  <= cfg_wdata[dsh_pkg::AMP_BITS-1:0];
        dsh_pkg::REG_CORNER_TL: corner_r[0] <= cfg_wdata[H-1:0];
        dsh_pkg::REG_CORNER_TR: corner_r[1] <= cfg_wdata[H-1:0];
        dsh_pkg::REG_CORNER_BL: corner_r[2] <= cfg_wdata[H-1:0];
        dsh_pkg::REG_CORNER_BR: corner_r[3] <= cfg_wdata[H-1:0];
        default: ;
      endcase
    end
  end

  logic [dsh_pkg::LVL_BITS-1:0] depth_eff;
  logic [dsh_pkg::LVL_BITS-1:0] sh;
  logic [dsh_pkg::IDX_BITS-1:0] h, pr, pc, rm, rp, cm, cp, n_side;
  logic [dsh_pkg::IDX_BITS-1:0] wr_row, wr_col, rd_row, rd_col, cn_row, cn_col;
  logic [dsh_pkg::SQ_BITS-1:0]  per_side_m1;
  logic                         col_end, row_end, lvl_end;

  always_comb begin
    if (depth_r == '0) begin
      depth_eff = dsh_pkg::LVL_BITS'(1);
    end else if (depth_r > dsh_pkg::LVL_BITS'(dsh_pkg::MAX_DEPTH)) begin
      depth_eff = dsh_pkg::LVL_BITS'(dsh_pkg::MAX_DEPTH);
    end else begin
      depth_eff = depth_r;
    end
  end

  // square centre: (2*index + 1) * h
  assign sh = gen_depth_r - dsh_pkg::LVL_BITS'(1) - level_r;
  assign h  = dsh_pkg::IDX_BITS'(1) << sh;
  assign pr = {sq_row_r, 1'b1} << sh;
  assign pc = {sq_col_r, 1'b1} << sh;
  assign rm = pr - h;
  assign rp = pr + h;
  assign cm = pc - h;
  assign cp = pc + h;

  always_comb begin
    unique case (phase_r)
      PH_CENTRE: begin wr_row = pr; wr_col = pc; end
      PH_TOP:    begin wr_row = rm; wr_col = pc; end
      PH_LEFT:   begin wr_row = pr; wr_col = cm; end
      PH_BOTTOM: begin wr_row = rp; wr_col = pc; end
      default:   begin wr_row = pr; wr_col = cp; end
    endcase
  end

  // corner read order: bit 0 picks the lower row, bit 1 the right column
  assign rd_row = cmd.rd_sel[0] ? rp : rm;
  assign rd_col = cmd.rd_sel[1] ? cp : cm;

  assign n_side = dsh_pkg::IDX_BITS'(1) << gen_depth_r;
  assign cn_row = cmd.corner_sel[1] ? n_side : '0;
  assign cn_col = cmd.corner_sel[0] ? n_side : '0;

  assign per_side_m1 = (dsh_pkg::SQ_BITS'(1) << level_r) - dsh_pkg::SQ_BITS'(1);
  assign col_end     = (sq_col_r == per_side_m1);
  assign row_end     = (sq_row_r == per_side_m1);
  assign lvl_end     = (level_r == gen_depth_r - dsh_pkg::LVL_BITS'(1));

  assign status.start_gen  = (level_r == '0) && (sq_row_r == '0) && (sq_col_r == '0)
                             && (phase_r == PH_CENTRE);
  assign status.phase_zero = (phase_r == PH_CENTRE);

  // grid memory: one write port, one registered read into the corner cache
  logic                          mem_we;
  logic [dsh_pkg::ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [H-1:0]                  mem_wdata;

  assign mem_we    = cmd.corner_wr || cmd.commit;
  assign mem_waddr = cmd.corner_wr ? grid_addr(cn_row, cn_col) : grid_addr(wr_row, wr_col);
  assign mem_wdata = cmd.corner_wr ? corner_r[cmd.corner_sel] : val_r;
  assign mem_raddr = grid_addr(rd_row, rd_col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      cache_r[cmd.rd_sel] <= grid_mem[mem_raddr];
    end
  end

  // arithmetic
  logic [dsh_pkg::AMP_BITS-1:0] amp_eff;
  logic signed [NOISE_W-1:0]    noise;
  logic signed [SUM_W-1:0]      sum_s;
  logic signed [TOT_W-1:0]      tot;
  logic [H-1:0]                 sat;

  assign amp_eff = status.start_gen ? init_amp_r : amp_r;

  // (rnd * 2 * amp) >> NOISE_BITS, minus amp
  assign noise = $signed({1'b0, prod_r[PROD_W-1:dsh_pkg::NOISE_BITS-1]})
                 - $signed({2'b00, amp_r});

  always_comb begin
    unique case (phase_r)
      PH_CENTRE: sum_s = sx(cache_r[0]) + sx(cache_r[1]) + sx(cache_r[2]) + sx(cache_r[3]);
      PH_TOP:    sum_s = sx(cache_r[0]) + sx(cache_r[2]) + (sx(centre_r) <<< 1);
      PH_LEFT:   sum_s = sx(cache_r[0]) + sx(cache_r[1]) + (sx(centre_r) <<< 1);
      PH_BOTTOM: sum_s = sx(cache_r[1]) + sx(cache_r[3]) + (sx(centre_r) <<< 1);
      default:   sum_s = sx(cache_r[2]) + sx(cache_r[3]) + (sx(centre_r) <<< 1);
    endcase
  end

  assign tot = {base_r[H-1], base_r} + {{(TOT_W - NOISE_W){noise_r[NOISE_W-1]}}, noise_r};

  always_comb begin
    if (tot[TOT_W-1] != tot[H-1]) begin
      sat = tot[TOT_W-1] ? {1'b1, {(H - 1){1'b0}}} : {1'b0, {(H - 1){1'b1}}};
    end else begin
      sat = tot[H-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prod_r <= PROD_W'(in_noise_word) * PROD_W'(amp_eff);
    end
    if (cmd.calc_base) begin
      base_r  <= sum_s[SUM_W-1:2];
      noise_r <= noise;
    end
    if (cmd.calc_final) begin
      val_r <= sat;
      if (phase_r == PH_CENTRE) begin
        centre_r <= sat;
      end
    end
  end

  // walk over levels, squares and points
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_depth_r <= dsh_pkg::LVL_BITS'(1);
      amp_r       <= dsh_pkg::AMP_BITS'(256);
      level_r     <= '0;
      sq_row_r    <= '0;
      sq_col_r    <= '0;
      phase_r     <= PH_CENTRE;
    end else if (cmd.take && status.start_gen) begin
      gen_depth_r <= depth_eff;
      amp_r       <= init_amp_r;
    end else if (cmd.commit) begin
      if (phase_r != PH_RIGHT) begin
        phase_r <= phase_r + 1'b1;
      end else begin
        phase_r <= PH_CENTRE;
        if (!col_end) begin
          sq_col_r <= sq_col_r + 1'b1;
        end else begin
          sq_col_r <= '0;
          if (!row_end) begin
            sq_row_r <= sq_row_r + 1'b1;
          end else begin
            sq_row_r <= '0;
            amp_r    <= amp_r >> rough_r;
            level_r  <= lvl_end ? '0 : level_r + 1'b1;
          end
        end
      end
    end
  end

  assign res_row    = wr_row;
  assign res_col    = wr_col;
  assign res_height = $signed(val_r);
  assign res_last   = (phase_r == PH_RIGHT) && col_end && row_end && lvl_end;

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_RIGHT)
    else $error("point phase beyond last edge");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r < gen_depth_r)
    else $error("level counter beyond generation depth");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_last) |=> status.start_gen)
    else $error("final point did not rewind the walk");

endmodule

`default_nettype wire
